### rtl/core/acrs_pkg.sv
// Shared types, constants and helpers for the associative cache replacement core.
// No dependencies; used by the top level of the core.
package acrs_pkg;

    localparam int ENTRIES   = 8;
    localparam int KEY_BITS  = 12;
    localparam int KEY_IN_W  = 12;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_SPACE = 1 << KEY_BITS;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int SLOT_W    = 3;
    localparam int KIND_W    = 2;
    localparam int POL_W     = 2;
    localparam int REC_W     = KEY_BITS + 2 * STAMP_W;

    // Replacement policy codes; the unused code behaves as FIFO.
    localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
    localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

    // Result classification codes.
    localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CAP  = 2'd2;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [STAMP_W-1:0]  t_stamp;
    typedef logic [CNT_W-1:0]    t_cnt;

    // One cache entry as it is held in the entry memory.
    typedef struct packed {
        t_key   key;
        t_stamp ins_stamp;
        t_stamp use_stamp;
    } t_rec;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CLOCK,
        ST_WRITE
    } t_state;

    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

### rtl/core/acrs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module acrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/assoc_cache_replacement_sim_core.sv
// Fully associative cache replacement engine: hit detection, FIFO/LRU/CLOCK eviction.
// Depends on acrs_pkg and acrs_ram.
//
// The core models a fully associative cache of acrs_pkg::ENTRIES entries and
// reports, for every key it accepts, whether the key hit, how a miss is
// classified (compulsory or capacity), which entry was hit or filled, whether a
// valid entry was evicted, and the running saturating miss counts. It works on
// one item at a time. An item is accepted, then goes through the associative
// search (one entry record read from the entry memory per cycle) and is then
// written back. When a key misses while the cache is full and the CLOCK policy
// is selected, a hand sweep between search and write-back clears set reference
// bits until it finds a clear one. After reset the core runs a clearing pass
// over the visited map, one entry per cycle, during which input stall stays
// high; policy writes are taken at any time. A finished result sits in an
// output register, and the next item is accepted while it waits; only the
// write-back of that next item waits for the output register to drain.
module assoc_cache_replacement_sim_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: policy register.
    input  logic                                i_cfg_wr_en,
    input  logic [acrs_pkg::POL_W-1:0]          i_cfg_wr_data,
    // Request channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [acrs_pkg::KEY_IN_W-1:0]       i_key,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [acrs_pkg::KIND_W-1:0]         o_miss_kind,
    output logic [acrs_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_evicted,
    output logic [acrs_pkg::CNT_W-1:0]          o_compulsory_count,
    output logic [acrs_pkg::CNT_W-1:0]          o_capacity_count
);

    localparam acrs_pkg::t_idx LAST_IDX = acrs_pkg::IDX_W'(acrs_pkg::ENTRIES - 1);

    // Control state.
    acrs_pkg::t_state                 r_state, n_state;
    logic [acrs_pkg::POL_W-1:0]       r_policy;
    logic [acrs_pkg::KEY_BITS-1:0]    r_clr_addr, n_clr_addr;
    logic [acrs_pkg::ENTRIES-1:0]     r_valid, n_valid;
    logic [acrs_pkg::ENTRIES-1:0]     r_ref, n_ref;
    acrs_pkg::t_idx                   r_hand, n_hand;
    acrs_pkg::t_cnt                   r_access, n_access;
    acrs_pkg::t_cnt                   r_comp, n_comp;
    acrs_pkg::t_cnt                   r_cap, n_cap;
    logic                             r_o_valid, n_o_valid;

    // Per-item working registers.
    acrs_pkg::t_key                   r_key, n_key;
    acrs_pkg::t_idx                   r_scan_idx, n_scan_idx;
    logic                             r_found, n_found;
    acrs_pkg::t_idx                   r_hit_idx, n_hit_idx;
    acrs_pkg::t_stamp                 r_hit_ins, n_hit_ins;
    acrs_pkg::t_idx                   r_min_ins_idx, n_min_ins_idx;
    acrs_pkg::t_stamp                 r_min_ins, n_min_ins;
    acrs_pkg::t_idx                   r_min_use_idx, n_min_use_idx;
    acrs_pkg::t_stamp                 r_min_use, n_min_use;
    logic                             r_seen, n_seen;
    acrs_pkg::t_idx                   r_slot, n_slot;
    logic                             r_evict, n_evict;

    // Result payload.
    logic                             r_o_hit, n_o_hit;
    logic [acrs_pkg::KIND_W-1:0]      r_o_kind, n_o_kind;
    logic [acrs_pkg::SLOT_W-1:0]      r_o_slot, n_o_slot;
    logic                             r_o_evicted, n_o_evicted;

    // Memory ports.
    logic                             ent_wr_en, ent_rd_en;
    acrs_pkg::t_idx                   ent_wr_addr, ent_rd_addr;
    acrs_pkg::t_rec                   ent_wr_data, ent_rd_data;
    logic                             vis_wr_en, vis_rd_en;
    acrs_pkg::t_key                   vis_wr_addr, vis_rd_addr;
    logic                             vis_wr_data, vis_rd_data;

    logic                             out_free;
    logic                             cur_match;
    logic                             scan_first;
    acrs_pkg::t_idx                   empty_idx;

    // Entry records: key, insert stamp and use stamp of each entry. Valid and
    // reference bits live in flip-flops so that reset clears them at once.
    acrs_ram #(
        .WIDTH (acrs_pkg::REC_W),
        .DEPTH (acrs_pkg::ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data)
    );

    // Visited map: one bit per key, set on every miss, cleared after reset.
    acrs_ram #(
        .WIDTH (1),
        .DEPTH (acrs_pkg::KEY_SPACE)
    ) u_visited_ram (
        .i_clk     (i_clk),
        .i_wr_en   (vis_wr_en),
        .i_wr_addr (vis_wr_addr),
        .i_wr_data (vis_wr_data),
        .i_rd_en   (vis_rd_en),
        .i_rd_addr (vis_rd_addr),
        .o_rd_data (vis_rd_data)
    );

    assign o_stall  = (r_state != acrs_pkg::ST_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    // Lowest-numbered empty entry; only used when some entry is empty.
    always_comb begin
        empty_idx = '0;
        for (int i = acrs_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                empty_idx = acrs_pkg::IDX_W'(i);
            end
        end
    end

    // The record read in the previous cycle belongs to entry r_scan_idx.
    assign scan_first = (r_scan_idx == '0);
    assign cur_match  = r_valid[r_scan_idx] && (ent_rd_data.key == r_key);

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_valid       = r_valid;
        n_ref         = r_ref;
        n_hand        = r_hand;
        n_access      = r_access;
        n_comp        = r_comp;
        n_cap         = r_cap;
        n_o_valid     = r_o_valid && i_stall;
        n_key         = r_key;
        n_scan_idx    = r_scan_idx;
        n_found       = r_found;
        n_hit_idx     = r_hit_idx;
        n_hit_ins     = r_hit_ins;
        n_min_ins_idx = r_min_ins_idx;
        n_min_ins     = r_min_ins;
        n_min_use_idx = r_min_use_idx;
        n_min_use     = r_min_use;
        n_seen        = r_seen;
        n_slot        = r_slot;
        n_evict       = r_evict;
        n_o_hit       = r_o_hit;
        n_o_kind      = r_o_kind;
        n_o_slot      = r_o_slot;
        n_o_evicted   = r_o_evicted;

        ent_wr_en   = 1'b0;
        ent_wr_addr = r_slot;
        ent_wr_data = '{key: r_key, ins_stamp: r_access, use_stamp: r_access};
        ent_rd_en   = 1'b0;
        ent_rd_addr = '0;
        vis_wr_en   = 1'b0;
        vis_wr_addr = r_key;
        vis_wr_data = 1'b1;
        vis_rd_en   = 1'b0;
        vis_rd_addr = r_key;

        unique case (r_state)
            acrs_pkg::ST_CLEAR: begin
                vis_wr_en   = 1'b1;
                vis_wr_addr = r_clr_addr;
                vis_wr_data = 1'b0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = acrs_pkg::ST_IDLE;
                end
            end

            acrs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_key       = acrs_pkg::KEY_BITS'(i_key);
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = '0;
                    vis_rd_en   = 1'b1;
                    vis_rd_addr = acrs_pkg::KEY_BITS'(i_key);
                    n_scan_idx  = '0;
                    n_state     = acrs_pkg::ST_SCAN;
                end
            end

            acrs_pkg::ST_SCAN: begin
                // Fold this entry into the running search results. The first
                // entry seeds the minima, so ties keep the lowest index.
                if (scan_first) begin
                    n_seen        = vis_rd_data;
                    n_found       = cur_match;
                    n_hit_idx     = '0;
                    n_hit_ins     = ent_rd_data.ins_stamp;
                    n_min_ins_idx = '0;
                    n_min_ins     = ent_rd_data.ins_stamp;
                    n_min_use_idx = '0;
                    n_min_use     = ent_rd_data.use_stamp;
                end else begin
                    if (cur_match && !r_found) begin
                        n_found   = 1'b1;
                        n_hit_idx = r_scan_idx;
                        n_hit_ins = ent_rd_data.ins_stamp;
                    end
                    if (ent_rd_data.ins_stamp < r_min_ins) begin
                        n_min_ins_idx = r_scan_idx;
                        n_min_ins     = ent_rd_data.ins_stamp;
                    end
                    if (ent_rd_data.use_stamp < r_min_use) begin
                        n_min_use_idx = r_scan_idx;
                        n_min_use     = ent_rd_data.use_stamp;
                    end
                end

                if (r_scan_idx != LAST_IDX) begin
                    ent_rd_en   = 1'b1;
                    ent_rd_addr = r_scan_idx + 1'b1;
                    n_scan_idx  = r_scan_idx + 1'b1;
                end else begin
                    n_state = acrs_pkg::ST_WRITE;
                    n_evict = 1'b0;
                    if (n_found) begin
                        n_slot = n_hit_idx;
                    end else if (!(&r_valid)) begin
                        n_slot = empty_idx;
                    end else begin
                        n_evict = 1'b1;
                        unique case (r_policy)
                            acrs_pkg::POL_LRU:   n_slot = n_min_use_idx;
                            acrs_pkg::POL_CLOCK: n_state = acrs_pkg::ST_CLOCK;
                            default:             n_slot = n_min_ins_idx;
                        endcase
                    end
                end
            end

            acrs_pkg::ST_CLOCK: begin
                // Second chance: clear set bits under the hand until a clear
                // one is found; the hand stays on the victim.
                if (!r_ref[r_hand]) begin
                    n_slot  = r_hand;
                    n_state = acrs_pkg::ST_WRITE;
                end else begin
                    n_ref[r_hand] = 1'b0;
                    n_hand        = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;
                end
            end

            acrs_pkg::ST_WRITE: begin
                // All updates of the item land together once the output
                // register can take its result.
                if (out_free) begin
                    ent_wr_en   = 1'b1;
                    ent_wr_addr = r_slot;
                    ent_wr_data = '{key:       r_key,
                                    ins_stamp: r_found ? r_hit_ins : r_access,
                                    use_stamp: r_access};
                    n_valid[r_slot] = 1'b1;
                    n_ref[r_slot]   = 1'b1;
                    n_access        = acrs_pkg::sat_inc(r_access);
                    n_o_hit         = r_found;
                    n_o_slot        = acrs_pkg::SLOT_W'(r_slot);
                    n_o_evicted     = r_evict && !r_found;
                    if (r_found) begin
                        n_o_kind = acrs_pkg::KIND_HIT;
                    end else begin
                        vis_wr_en = 1'b1;
                        if (r_seen) begin
                            n_o_kind = acrs_pkg::KIND_CAP;
                            n_cap    = acrs_pkg::sat_inc(r_cap);
                        end else begin
                            n_o_kind = acrs_pkg::KIND_COMP;
                            n_comp   = acrs_pkg::sat_inc(r_comp);
                        end
                    end
                    n_o_valid = 1'b1;
                    n_state   = acrs_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = acrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= acrs_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= '0;
            r_ref      <= '0;
            r_hand     <= '0;
            r_access   <= '0;
            r_comp     <= '0;
            r_cap      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
            r_ref      <= n_ref;
            r_hand     <= n_hand;
            r_access   <= n_access;
            r_comp     <= n_comp;
            r_cap      <= n_cap;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= acrs_pkg::POL_FIFO;
        end else if (i_cfg_wr_en) begin
            r_policy <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_scan_idx    <= n_scan_idx;
        r_found       <= n_found;
        r_hit_idx     <= n_hit_idx;
        r_hit_ins     <= n_hit_ins;
        r_min_ins_idx <= n_min_ins_idx;
        r_min_ins     <= n_min_ins;
        r_min_use_idx <= n_min_use_idx;
        r_min_use     <= n_min_use;
        r_seen        <= n_seen;
        r_slot        <= n_slot;
        r_evict       <= n_evict;
        r_o_hit       <= n_o_hit;
        r_o_kind      <= n_o_kind;
        r_o_slot      <= n_o_slot;
        r_o_evicted   <= n_o_evicted;
    end

    // The counts change only at a write-back, which waits for the output
    // register to drain, so they hold steady with the result they belong to.
    assign o_valid            = r_o_valid;
    assign o_hit              = r_o_hit;
    assign o_miss_kind        = r_o_kind;
    assign o_slot             = r_o_slot;
    assign o_evicted          = r_o_evicted;
    assign o_compulsory_count = r_comp;
    assign o_capacity_count   = r_cap;

`ifndef ASSERT_OFF
    // No entry may be valid or referenced while the visited map is cleared.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acrs_pkg::ST_CLEAR) |-> (r_valid == '0) && (r_ref == '0))
        else $error("entries live during visited map clearing");

    // An eviction is only chosen when every entry holds a key.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acrs_pkg::ST_WRITE) && r_evict && !r_found |-> (&r_valid))
        else $error("eviction chosen with an empty entry");

    // A write-back always presents a result in the next cycle.
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acrs_pkg::ST_WRITE) && out_free |=> o_valid)
        else $error("write-back without a result");

    // The entry that was hit or filled is valid and referenced afterwards.
    a_slot_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == acrs_pkg::ST_WRITE) && out_free |=>
            r_valid[$past(r_slot)] && r_ref[$past(r_slot)])
        else $error("written entry not marked valid and referenced");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for assoc_cache_replacement_sim_core, the fully associative cache
// with FIFO, LRU and CLOCK replacement. Depends on acrs_pkg and on the RTL of the core;
// expected results come from a predictor in this file, or are typed by hand in some rows.
module tb;

    // The policy code that has no meaning of its own; the core treats it as FIFO.
    localparam logic [acrs_pkg::POL_W-1:0] POL_SPARE = 2'd3;

    // Run shape. The random part stops once the total number of keys sent reaches
    // KEYS_TOTAL. The receiver holds off once, after LONG_HOLD_AT results have been
    // taken.
    localparam int KEYS_TOTAL       = 1925;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES      = 40;
    localparam int CYCLE_LIMIT      = 600000;

    // One lookup outcome, laid out as the result channel presents it.
    typedef struct packed {
        logic                        hit;
        logic [acrs_pkg::KIND_W-1:0] kind;
        logic [acrs_pkg::SLOT_W-1:0] slot;
        logic                        evicted;
        acrs_pkg::t_cnt              comp;
        acrs_pkg::t_cnt              cap;
    } t_outcome;

    // One row of the directed table: the policy to run under, the key, and where
    // the outcome is obvious, the outcome itself.
    typedef struct {
        logic [acrs_pkg::POL_W-1:0] pol;
        acrs_pkg::t_key             key;
        bit                         typed;
        t_outcome                   exp;
    } t_dir_row;

    // Receiver stall patterns.
    typedef enum int {
        SINK_FREE,
        SINK_LIGHT,
        SINK_HALF,
        SINK_BEAT,
        SINK_HEAVY
    } t_sink_mode;

    logic                          i_clk;
    logic                          i_rst_n            = 1'b0;
    logic                          i_cfg_wr_en        = 1'b0;
    logic [acrs_pkg::POL_W-1:0]    i_cfg_wr_data      = '0;
    logic                          i_valid            = 1'b0;
    logic [acrs_pkg::KEY_IN_W-1:0] i_key              = '0;
    logic                          i_stall            = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic                          o_hit;
    logic [acrs_pkg::KIND_W-1:0]   o_miss_kind;
    logic [acrs_pkg::SLOT_W-1:0]   o_slot;
    logic                          o_evicted;
    logic [acrs_pkg::CNT_W-1:0]    o_compulsory_count;
    logic [acrs_pkg::CNT_W-1:0]    o_capacity_count;

    assoc_cache_replacement_sim_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_key              (i_key),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_hit              (o_hit),
        .o_miss_kind        (o_miss_kind),
        .o_slot             (o_slot),
        .o_evicted          (o_evicted),
        .o_compulsory_count (o_compulsory_count),
        .o_capacity_count   (o_capacity_count)
    );

    // Predicted cache contents. Keys and stamps of an entry are only read once
    // the entry has been filled, so their start values do not matter.
    logic                       line_valid [acrs_pkg::ENTRIES];
    acrs_pkg::t_key             line_key   [acrs_pkg::ENTRIES];
    acrs_pkg::t_stamp           line_ins   [acrs_pkg::ENTRIES];
    acrs_pkg::t_stamp           line_use   [acrs_pkg::ENTRIES];
    logic                       line_ref   [acrs_pkg::ENTRIES];
    bit                         seen_key   [acrs_pkg::KEY_SPACE];
    int                         sweep_hand = 0;
    acrs_pkg::t_cnt             access_cnt = '0;
    acrs_pkg::t_cnt             comp_cnt   = '0;
    acrs_pkg::t_cnt             cap_cnt    = '0;
    logic [acrs_pkg::POL_W-1:0] policy_sel = acrs_pkg::POL_FIFO;

    // Outcomes of accepted keys, oldest first, waiting for the result channel.
    t_outcome outcome_q [$];
    t_dir_row dir_rows  [$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  keys_sent      = 0;
    int  policy_writes  = 0;
    int  hit_total      = 0;
    int  comp_total     = 0;
    int  cap_total      = 0;
    int  evict_total    = 0;
    int  burst_left     = 0;
    int  cycle_count    = 0;
    bit  long_hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a correct run finishes far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, outcome_q.size());
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic acrs_pkg::t_cnt sat_bump(input acrs_pkg::t_cnt v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Lowest-numbered entry holding the smallest stamp.
    function automatic int oldest_index(input acrs_pkg::t_stamp stamps [acrs_pkg::ENTRIES]);
        int best;
        best = 0;
        for (int i = 1; i < acrs_pkg::ENTRIES; i++)
            if (stamps[i] < stamps[best])
                best = i;
        return best;
    endfunction

    // Looks one key up in the predicted cache, updates the cache as the core
    // should, and returns the outcome the core should report.
    function automatic t_outcome predict_lookup(input acrs_pkg::t_key k);
        t_outcome r;
        int       hit_at;
        int       free_at;
        int       victim;
        r       = '0;
        hit_at  = -1;
        free_at = -1;
        victim  = 0;
        // The lowest-numbered valid entry that holds the key wins.
        for (int i = 0; i < acrs_pkg::ENTRIES; i++)
            if (hit_at < 0 && line_valid[i] && line_key[i] == k)
                hit_at = i;
        if (hit_at >= 0) begin
            line_use[hit_at] = access_cnt;
            line_ref[hit_at] = 1'b1;
            r.hit  = 1'b1;
            r.kind = acrs_pkg::KIND_HIT;
            r.slot = acrs_pkg::SLOT_W'(hit_at);
        end else begin
            // A key requested at any earlier time misses for lack of room.
            if (seen_key[k]) begin
                r.kind  = acrs_pkg::KIND_CAP;
                cap_cnt = sat_bump(cap_cnt);
            end else begin
                r.kind   = acrs_pkg::KIND_COMP;
                comp_cnt = sat_bump(comp_cnt);
            end
            for (int i = 0; i < acrs_pkg::ENTRIES; i++)
                if (free_at < 0 && !line_valid[i])
                    free_at = i;
            if (free_at >= 0) begin
                victim = free_at;
            end else begin
                r.evicted = 1'b1;
                if (policy_sel == acrs_pkg::POL_LRU) begin
                    victim = oldest_index(line_use);
                end else if (policy_sel == acrs_pkg::POL_CLOCK) begin
                    // Second chance: clear set bits while the hand moves on; the
                    // hand stops on the first clear bit, which is the victim.
                    for (int n = 0; n <= acrs_pkg::ENTRIES; n++) begin
                        if (!line_ref[sweep_hand])
                            break;
                        line_ref[sweep_hand] = 1'b0;
                        sweep_hand = (sweep_hand + 1) % acrs_pkg::ENTRIES;
                    end
                    victim = sweep_hand;
                end else begin
                    // FIFO, and the spare code as well.
                    victim = oldest_index(line_ins);
                end
            end
            line_valid[victim] = 1'b1;
            line_key[victim]   = k;
            line_ins[victim]   = access_cnt;
            line_use[victim]   = access_cnt;
            line_ref[victim]   = 1'b1;
            seen_key[k]        = 1'b1;
            r.slot             = acrs_pkg::SLOT_W'(victim);
        end
        access_cnt = sat_bump(access_cnt);
        r.comp = comp_cnt;
        r.cap  = cap_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Rows whose outcome comes from the predictor.
    task automatic add_row(input logic [acrs_pkg::POL_W-1:0] pol, input acrs_pkg::t_key k);
        t_dir_row row;
        row.pol   = pol;
        row.key   = k;
        row.typed = 1'b0;
        row.exp   = '0;
        dir_rows.push_back(row);
    endtask

    // Rows whose outcome is written out by hand.
    task automatic add_typed(input logic [acrs_pkg::POL_W-1:0] pol, input acrs_pkg::t_key k,
                             input logic hit, input logic [acrs_pkg::KIND_W-1:0] kind,
                             input int slot, input logic ev, input int comp, input int cap);
        t_dir_row row;
        row.pol         = pol;
        row.key         = k;
        row.typed       = 1'b1;
        row.exp.hit     = hit;
        row.exp.kind    = kind;
        row.exp.slot    = acrs_pkg::SLOT_W'(slot);
        row.exp.evicted = ev;
        row.exp.comp    = acrs_pkg::t_cnt'(comp);
        row.exp.cap     = acrs_pkg::t_cnt'(cap);
        dir_rows.push_back(row);
    endtask

    // Offers one key and returns at the clock edge that accepts it. The
    // predictor runs at acceptance; a hand-written outcome, where given, is
    // what gets checked, while the predictor still tracks the cache.
    task automatic push_key(input acrs_pkg::t_key k, input bit typed, input t_outcome typed_exp);
        t_outcome pred;
        i_valid <= 1'b1;
        i_key   <= k;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pred = predict_lookup(k);
        outcome_q.push_back(typed ? typed_exp : pred);
        keys_sent++;
    endtask

    // Bursts of back-to-back items with random gaps between them. A third of
    // the bursts have no gap in front, so long stretches run without idling.
    // The gap comes before the item so that valid is only ever lowered at a
    // step where nothing raises it.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Stops offering and waits until every expected result has been taken,
    // which leaves the core idle since every key yields exactly one result.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_policy(input logic [acrs_pkg::POL_W-1:0] p);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= p;
        @(posedge i_clk);
        policy_sel = p;
        policy_writes++;
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [acrs_pkg::POL_W-1:0] pol_cycle [4];
        acrs_pkg::t_key             pool [16];
        int                         pool_size;
        int                         phase_len;
        int                         phase_no;
        acrs_pkg::t_key             k;

        pol_cycle = '{acrs_pkg::POL_LRU, acrs_pkg::POL_CLOCK, acrs_pkg::POL_FIFO, POL_SPARE};
        for (int i = 0; i < acrs_pkg::ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_ref[i]   = 1'b0;
            line_key[i]   = '0;
            line_ins[i]   = '0;
            line_use[i]   = '0;
        end

        // Directed table. Under FIFO the first keys fill the entries in order,
        // which gives the key extremes and a first hit.
        add_typed(acrs_pkg::POL_FIFO, 12'h000, 1'b0, acrs_pkg::KIND_COMP, 0, 1'b0, 1, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'hFFF, 1'b0, acrs_pkg::KIND_COMP, 1, 1'b0, 2, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h000, 1'b1, acrs_pkg::KIND_HIT,  0, 1'b0, 2, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h555, 1'b0, acrs_pkg::KIND_COMP, 2, 1'b0, 3, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'hAAA, 1'b0, acrs_pkg::KIND_COMP, 3, 1'b0, 4, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h001, 1'b0, acrs_pkg::KIND_COMP, 4, 1'b0, 5, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h800, 1'b0, acrs_pkg::KIND_COMP, 5, 1'b0, 6, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h7FF, 1'b0, acrs_pkg::KIND_COMP, 6, 1'b0, 7, 0);
        add_typed(acrs_pkg::POL_FIFO, 12'h123, 1'b0, acrs_pkg::KIND_COMP, 7, 1'b0, 8, 0);
        // Full cache: the oldest insert goes even though it was just hit, and
        // keys coming back after eviction count as capacity misses.
        add_row(acrs_pkg::POL_FIFO, 12'h456);
        add_row(acrs_pkg::POL_FIFO, 12'h000);
        add_row(acrs_pkg::POL_FIFO, 12'hFFF);
        // LRU: a hit refreshes an entry so that it outlives older uses.
        add_row(acrs_pkg::POL_LRU, 12'h555);
        add_row(acrs_pkg::POL_LRU, 12'h456);
        add_row(acrs_pkg::POL_LRU, 12'h999);
        add_row(acrs_pkg::POL_LRU, 12'hABC);
        add_row(acrs_pkg::POL_LRU, 12'h555);
        // CLOCK: every entry has its reference bit set, so the first sweep goes
        // all the way round before it finds a clear bit.
        add_row(acrs_pkg::POL_CLOCK, 12'h001);
        add_row(acrs_pkg::POL_CLOCK, 12'hDEF);
        add_row(acrs_pkg::POL_CLOCK, 12'h7FF);
        add_row(acrs_pkg::POL_CLOCK, 12'h321);
        add_row(acrs_pkg::POL_CLOCK, 12'h654);
        // The spare policy code must act exactly like FIFO.
        add_row(POL_SPARE, 12'h0F0);
        add_row(POL_SPARE, 12'hF0F);
        add_row(POL_SPARE, 12'h000);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The policy write lands during the clearing pass, while input stall is
        // still high; the first key simply waits for the pass to finish.
        set_policy(acrs_pkg::POL_FIFO);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].pol != policy_sel) begin
                drain_results();
                set_policy(dir_rows[r].pol);
            end
            pace_sender();
            push_key(dir_rows[r].key, dir_rows[r].typed, dir_rows[r].exp);
        end

        // Random phases, one policy each. Keys come mostly from a small pool
        // whose size sits around the number of entries, so hits, evictions and
        // long CLOCK sweeps are all common; the rest span the whole key range.
        // Each phase boundary drains the core completely before the write.
        phase_no = 0;
        while (keys_sent < KEYS_TOTAL) begin
            drain_results();
            set_policy((phase_no < 4) ? pol_cycle[phase_no] : pol_cycle[$urandom_range(0, 3)]);
            pool_size = $urandom_range(3, 14);
            for (int i = 0; i < pool_size; i++)
                pool[i] = acrs_pkg::t_key'($urandom_range(0, acrs_pkg::KEY_SPACE - 1));
            phase_len = $urandom_range(120, 260);
            for (int i = 0; i < phase_len && keys_sent < KEYS_TOTAL; i++) begin
                pace_sender();
                if ($urandom_range(0, 3) != 0)
                    k = pool[$urandom_range(0, pool_size - 1)];
                else
                    k = acrs_pkg::t_key'($urandom_range(0, acrs_pkg::KEY_SPACE - 1));
                push_key(k, 1'b0, '0);
            end
            phase_no++;
        end

        drain_results();
        // Let anything stray come out before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d keys across %0d policy writes, the spare code included.",
                 keys_sent, policy_writes);
        $display("Results: %0d hits, %0d compulsory, %0d capacity misses, %0d evictions.",
                 hit_total, comp_total, cap_total, evict_total);
        if (mismatch_count == 0 && outcome_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0t: %0d mismatches, %0d results never arrived", $time,
                     mismatch_count, outcome_q.size());
            $display("tb failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver changes its stall pattern at random. Once,
    // part way into the run and while a key is on offer, it holds stall high
    // for a long stretch while the sender keeps offering, so the core fills up
    // and stalls its input.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        mode      = SINK_FREE;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= LONG_HOLD_AT && i_valid) begin
                long_hold_done = 1'b1;
                i_stall <= 1'b1;
                for (int held = 0; held < LONG_HOLD_CYCLES; held++)
                    @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 4));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                SINK_FREE: begin
                    i_stall <= 1'b0;
                end
                SINK_LIGHT: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                SINK_HALF: begin
                    i_stall <= 1'($urandom_range(0, 1));
                end
                SINK_BEAT: begin
                    // Ready whenever mode_left is a multiple of four.
                    i_stall <= (mode_left % 4 != 0);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 9) < 8);
                end
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every result taken is compared with the oldest outcome still waiting.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing expected, slot %0d", $time, o_slot);
                mismatch_count++;
            end else begin
                want = outcome_q.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("miss_kind", 32'(want.kind), 32'(o_miss_kind));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("evicted", 32'(want.evicted), 32'(o_evicted));
                check_field("compulsory_count", want.comp, o_compulsory_count);
                check_field("capacity_count", want.cap, o_capacity_count);
                if (o_hit === 1'b1)
                    hit_total++;
                if (o_miss_kind === acrs_pkg::KIND_COMP)
                    comp_total++;
                if (o_miss_kind === acrs_pkg::KIND_CAP)
                    cap_total++;
                if (o_evicted === 1'b1)
                    evict_total++;
            end
        end
    end

endmodule

### filelist.f
rtl/core/acrs_pkg.sv
rtl/core/acrs_ram.sv
rtl/core/assoc_cache_replacement_sim_core.sv
tb/sv/tb.sv
